/* sv/wlc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_pkg
// Shared types and constants for the wear-levelled counter core.
// ----------------------------------------------------------------------------
package wlc_pkg;

  // operation codes carried in the input tuser field
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_INCR  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;
  localparam logic [1:0] OP_SET   = 2'd3;

  // counter and register widths
  localparam int VALUE_W = 64;
  localparam int CFG_W   = 11;
  localparam int CNT_W   = 7;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(VALUE_W - 1);

  // slots register value after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT,
    ST_MUL,
    ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;      // capture the transaction and apply quick updates
    logic div_step;    // one restoring division step
    logic div_commit;  // quotient to overflow word, remainder to fill count
    logic mul_clr;     // start the shift-add product
    logic mul_step;    // one shift-add product step
    logic out_load;    // load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;    // result register can take a new result
  } status_t;

endpackage

/* sv/wlc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_ctrl
// Sequencer: accepts one operation, runs the divide steps (set only) and the
// multiply steps, then hands the result to the output register.
// ----------------------------------------------------------------------------
module wlc_ctrl #(
  parameter int NW = 11
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  input  logic [1:0]      opcode,
  input  wlc_pkg::status_t status,
  output logic            s_ready,
  output wlc_pkg::cmd_t   cmd
);
  import wlc_pkg::*;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(NW - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.accept = 1'b1;
          cnt_next   = '0;
          if (opcode == OP_SET) begin
            state_next = ST_DIV;
          end else begin
            cmd.mul_clr = 1'b1;
            state_next  = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.div_commit = 1'b1;
        cmd.mul_clr    = 1'b1;
        cnt_next       = '0;
        state_next     = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* sv/wlc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_datapath
// Counter state (overflow word and programmed-slot fill count), slots
// register, bit-serial divider, shift-add multiplier and result register.
// ----------------------------------------------------------------------------
module wlc_datapath #(
  parameter int SLOT_COUNT = 1024,
  parameter int NW         = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wlc_pkg::cmd_t               cmd,
  output wlc_pkg::status_t            status,
  input  logic                        cfg_write,
  input  logic [wlc_pkg::CFG_W-1:0]   cfg_data,
  input  logic [1:0]                  opcode,
  input  logic [wlc_pkg::VALUE_W-1:0] set_value,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [wlc_pkg::VALUE_W-1:0] m_tdata,
  output logic                        m_tuser
);
  import wlc_pkg::*;

  localparam int CW = (NW > CFG_W) ? NW : CFG_W;
  localparam int RW = NW + 1;

  logic [CFG_W-1:0]   slots;
  logic [CW-1:0]      slots_x;
  logic [NW-1:0]      n_act;
  logic [NW-1:0]      fill;       // programmed slots form a prefix of this length
  logic [NW-1:0]      lead;
  logic [VALUE_W-1:0] ovf;
  logic               rolled;
  logic [VALUE_W-1:0] dq;
  logic [RW-1:0]      rem;
  logic [RW-1:0]      rem_sh;
  logic               rem_ge;
  logic [VALUE_W-1:0] acc;
  logic [NW-1:0]      mulr;

  // slots register
  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= CFG_RESET;
    end else if (cfg_write) begin
      slots <= cfg_data;
    end
  end

  // slots in use, clamped to one and to the slot area size
  assign slots_x = CW'(slots);
  always_comb begin
    if (slots_x == '0) begin
      n_act = NW'(1);
    end else if (slots_x > CW'(SLOT_COUNT)) begin
      n_act = NW'(SLOT_COUNT);
    end else begin
      n_act = slots_x[NW-1:0];
    end
  end

  // programmed slots counted before the first erased one
  assign lead = (fill < n_act) ? fill : n_act;

  // restoring division step
  assign rem_sh = {rem[NW-1:0], dq[VALUE_W-1]};
  assign rem_ge = rem_sh >= RW'(n_act);

  // counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf  <= '0;
      fill <= '0;
    end else if (cmd.accept) begin
      case (opcode)
        OP_INCR: begin
          if (fill < n_act) begin
            fill <= fill + 1'b1;
          end else begin
            ovf  <= ovf + 1'b1;
            fill <= NW'(1);
          end
        end
        OP_RESET: begin
          ovf  <= '0;
          fill <= '0;
        end
        default: ;
      endcase
    end else if (cmd.div_commit) begin
      ovf  <= dq;
      fill <= rem[NW-1:0];
    end
  end

  // roll-over flag of the current transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rolled <= (opcode == OP_INCR) && !(fill < n_act);
    end
  end

  // divider: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dq  <= set_value;
      rem <= '0;
    end else if (cmd.div_step) begin
      dq  <= {dq[VALUE_W-2:0], rem_ge};
      rem <= rem_ge ? (rem_sh - RW'(n_act)) : rem_sh;
    end
  end

  // shift-add product of overflow word and slots in use, msb first
  always_ff @(posedge clk) begin
    if (cmd.mul_clr) begin
      acc  <= '0;
      mulr <= n_act;
    end else if (cmd.mul_step) begin
      acc  <= {acc[VALUE_W-2:0], 1'b0} + (mulr[NW-1] ? ovf : '0);
      mulr <= {mulr[NW-2:0], 1'b0};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= acc + VALUE_W'(lead);
      m_tuser <= rolled;
    end
  end

  assign status.out_free = !m_tvalid || m_tready;

endmodule

/* sv/wear_leveled_counter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wear_leveled_counter_core
// Wear-levelled unary counter: overflow word times slots in use plus the
// programmed-slot prefix, with read, increment, reset and set operations.
// ----------------------------------------------------------------------------
//  channel  dir   handshake               payload
//  s_*      in    s_tvalid / s_tready     tdata set_value, tuser opcode
//  m_*      out   m_tvalid / m_tready     tdata count_value, tuser rolled_over
//  cfg_*    in    cfg_valid / cfg_ready   cfg_data slots in use
//
//  read, increment and reset run the shift-add multiply after accept, then
//  load the result register; set first runs the bit-serial 64-bit divide.
//  one operation in flight; s_tready is high only while idle, the result
//  register holds until m_tready. synchronous reset clears the counter to
//  zero and sets the slots register to 1024; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wear_leveled_counter_core #(
  parameter int SLOT_COUNT = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [wlc_pkg::VALUE_W-1:0] s_tdata,   // [63:0] set_value
  input  logic [1:0]                  s_tuser,   // [1:0] opcode
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [wlc_pkg::VALUE_W-1:0] m_tdata,   // [63:0] count_value
  output logic                        m_tuser,   // [0] rolled_over
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wlc_pkg::CFG_W-1:0]   cfg_data
);
  import wlc_pkg::*;

  localparam int NW = $clog2(SLOT_COUNT + 1);

  cmd_t    cmd;
  status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // sequencer
  wlc_ctrl #(
    .NW(NW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .opcode  (s_tuser),
    .status  (status),
    .s_ready (s_tready),
    .cmd     (cmd)
  );

  // counter state and arithmetic
  wlc_datapath #(
    .SLOT_COUNT(SLOT_COUNT),
    .NW        (NW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .opcode    (s_tuser),
    .set_value (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* sv/wlc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_checker
// Port-level checks of the counter core, bound to the top level.
// ----------------------------------------------------------------------------
module wlc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [1:0]                  s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [wlc_pkg::VALUE_W-1:0] m_tdata,
  input logic                        m_tuser
);
  import wlc_pkg::*;

  logic [1:0] op_q [2];
  logic [1:0] op_cnt;
  logic       push;
  logic       pop;

  assign push = s_tvalid && s_tready;
  assign pop  = m_tvalid && m_tready;

  // opcodes of transactions whose results are still owed, oldest first
  always_ff @(posedge clk) begin
    if (rst) begin
      op_cnt <= '0;
    end else begin
      case ({push, pop})
        2'b10: begin
          op_q[op_cnt[0]] <= s_tuser;
          op_cnt          <= op_cnt + 1'b1;
        end
        2'b01: begin
          op_q[0] <= op_q[1];
          op_cnt  <= op_cnt - 1'b1;
        end
        2'b11: begin
          if (op_cnt == 2'd1) begin
            op_q[0] <= s_tuser;
          end else begin
            op_q[0] <= op_q[1];
            op_q[1] <= s_tuser;
          end
        end
        default: ;
      endcase
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one operation at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // roll-over only reported for increment
  a_roll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> op_q[0] == OP_INCR)
    else $error("roll-over flag on non-increment");

  // reset gives a zero count
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && op_q[0] == OP_RESET |-> m_tdata == '0)
    else $error("reset result not zero");

  // no result straight after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind wear_leveled_counter_core wlc_checker u_wlc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wear-levelled counter core. A behavioural
// counter (slot marks, overflow word, slots register) predicts every result,
// and each result transaction is checked against the oldest prediction. The
// tests cover reset state, all operations with extreme values, roll-over,
// clamping of the slots register, hidden marks after a shrink, and random
// operation mixes under several slot settings with random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import wlc_pkg::*;

  localparam int SLOTS = 1024;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    logic [VALUE_W-1:0] count;
    logic               rolled;
  } count_result_t;

  logic clk = 1'b0;
  logic rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata;   // [63:0] set_value
  logic [1:0]         s_tuser;   // [1:0] opcode
  logic               m_tvalid;
  logic               m_tready;
  logic [VALUE_W-1:0] m_tdata;   // [63:0] count_value
  logic               m_tuser;   // [0] rolled_over
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data;

  // counter shadow state
  bit [SLOTS-1:0]     slot_prog;
  logic [VALUE_W-1:0] ovf_word;
  logic [CFG_W-1:0]   slot_reg;

  count_result_t count_q[$];
  int  mismatches = 0;
  int  cycle_cnt = 0;
  bit  calm = 1'b0;

  wear_leveled_counter_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // behavioural counter
  // ---------------------------------------------------------------------------

  // slots register clamped to the usable range
  function automatic int unsigned slots_active();
    int unsigned n;
    n = slot_reg;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // programmed run from slot 0, limited to n
  function automatic int unsigned prefix_len(input int unsigned n);
    int unsigned i;
    i = 0;
    while (i < n && slot_prog[i]) i++;
    return i;
  endfunction

  // apply one operation to the shadow counter and queue the expected result
  task automatic predict_op(input logic [1:0] op, input logic [VALUE_W-1:0] val);
    int unsigned   n;
    int unsigned   idx;
    logic [VALUE_W-1:0] rem;
    count_result_t res;
    n = slots_active();
    res.rolled = 1'b0;
    case (op)
      OP_INCR: begin
        idx = prefix_len(n);
        if (idx < n) begin
          slot_prog[idx] = 1'b1;
        end else begin
          ovf_word = ovf_word + 64'd1;
          slot_prog = '0;
          slot_prog[0] = 1'b1;
          res.rolled = 1'b1;
        end
      end
      OP_RESET: begin
        ovf_word = '0;
        slot_prog = '0;
      end
      OP_SET: begin
        rem = val % 64'(n);
        ovf_word = val / 64'(n);
        slot_prog = '0;
        for (int unsigned i = 0; i < rem; i++) slot_prog[i] = 1'b1;
      end
      default: ;
    endcase
    res.count = ovf_word * 64'(n) + 64'(prefix_len(n));
    count_q.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one operation transaction, with an optional random gap in front
  task automatic send_op(input logic [1:0] op, input logic [VALUE_W-1:0] val);
    if (!calm && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_op(op, val);
  endtask

  // hold off the sender until every expected result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (count_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // slots register write, only with the core idle
  task automatic write_slots(input logic [CFG_W-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slot_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // result sink with random stall bursts
  initial begin
    m_tready <= 1'b0;
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    count_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (count_q.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] result with nothing expected: count %h rolled %b",
                   $time, m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = count_q.pop_front();
        if (m_tdata !== want.count || m_tuser !== want.rolled) begin
          if (mismatches < 10)
            $display("[%0t] count exp %h got %h, rolled exp %b got %b", $time,
                     want.count, m_tdata, want.rolled, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // set values: wide random, small, just below a roll-over, near the top
  function automatic logic [VALUE_W-1:0] pick_set_value(input int unsigned n);
    logic [VALUE_W-1:0] v;
    int unsigned        k;
    k = (n > 4) ? 3 : n - 1;
    case ($urandom_range(0, 4))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 3 * n));
      2: v = 64'($urandom_range(0, 1000)) * 64'(n) + 64'(n - 1 - $urandom_range(0, k));
      3: v = '1 - 64'($urandom_range(0, 2 * n));
      default: v = {$urandom, $urandom} >> $urandom_range(1, 63);
    endcase
    return v;
  endfunction

  // one random operation, weighted towards increment
  task automatic send_random_op();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10)      send_op(OP_INCR, {$urandom, $urandom});
    else if (r < 13) send_op(OP_READ, {$urandom, $urandom});
    else if (r < 14) send_op(OP_RESET, {$urandom, $urandom});
    else             send_op(OP_SET, pick_set_value(slots_active()));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // counter reads zero after reset and counts up
  task automatic test_reset_state();
    send_op(OP_READ, '0);
    send_op(OP_INCR, '1);
    send_op(OP_READ, '0);
  endtask

  // every operation with extreme set values at 1024 slots
  task automatic test_operations();
    send_op(OP_SET, '0);
    send_op(OP_SET, '1);
    send_op(OP_SET, 64'h5555_5555_5555_5555);
    send_op(OP_SET, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(OP_INCR, '0);
    send_op(OP_READ, '1);
    send_op(OP_RESET, '1);
    send_op(OP_READ, '0);
  endtask

  // full area on increment bumps the overflow word
  task automatic test_rollover();
    send_op(OP_SET, 64'd2047);
    send_op(OP_INCR, '0);
    send_op(OP_INCR, '0);
    send_op(OP_READ, '0);
  endtask

  // slots register zero acts as one, above the area saturates
  task automatic test_slot_clamp();
    write_slots(11'd0);
    send_op(OP_SET, '1);
    send_op(OP_INCR, '0);
    send_op(OP_INCR, '0);
    write_slots(11'd2047);
    send_op(OP_SET, '1);
    send_op(OP_INCR, '0);
  endtask

  // marks beyond a shrunk area stay but are not counted
  task automatic test_hidden_marks();
    write_slots(11'd8);
    send_op(OP_SET, 64'd6);
    write_slots(11'd4);
    send_op(OP_READ, '0);
    write_slots(11'd8);
    send_op(OP_READ, '0);
    write_slots(11'd4);
    send_op(OP_INCR, '0);
    write_slots(11'd8);
    send_op(OP_READ, '0);
  endtask

  // random operation mixes over a range of slot settings
  task automatic test_random_mix(input int per_setting);
    logic [CFG_W-1:0] settings[10];
    settings = '{11'd1, 11'd2, 11'd3, 11'd5, 11'd8, 11'd1024, 11'd2047, 11'd0,
                 11'd1023, 11'd1};
    settings[9] = CFG_W'($urandom_range(1, 2047));
    foreach (settings[i]) begin
      write_slots(settings[i]);
      repeat (per_setting) begin
        if ($urandom_range(0, 24) == 0) drain_results();
        send_random_op();
      end
    end
  endtask

  // closing stretch with both sides always ready
  task automatic test_back_to_back(input int count);
    write_slots(CFG_W'($urandom_range(2, 6)));
    calm = 1'b1;
    repeat (count) send_random_op();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_READ;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    slot_prog = '0;
    ovf_word  = '0;
    slot_reg  = CFG_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_operations();
    test_rollover();
    test_slot_clamp();
    test_hidden_marks();
    test_random_mix(38);
    test_back_to_back(50);

    drain_results();
    repeat (20) @(posedge clk);
    if (count_q.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
